/* design/base64_stream_decoder_unit_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the base64 stream decoder
// Shared concurrent assertion forms; define NO_ASSERTIONS to drop them.
// ----------------------------------------------------------------------------
`ifndef BASE64_STREAM_DECODER_UNIT_ASSERT_SVH
`define BASE64_STREAM_DECODER_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Checked at every edge outside reset.
`define B64D_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked at every edge, reset included.
`define B64D_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define B64D_ASSERT(lbl, prop, msg)
`define B64D_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

/* design/b64d_pkg.sv */
// ----------------------------------------------------------------------------
// b64d_pkg
// Types, constants and the alphabet lookup of the base64 stream decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

  localparam int COUNT_WIDTH_DEFAULT = 16;
  localparam int QUEUE_DEPTH         = 4;
  localparam int QUEUE_AW            = $clog2(QUEUE_DEPTH);

  localparam logic [1:0] GROUP_FULL = 2'd3;

  // One decoded group handed from front to back.
  typedef struct packed {
    logic [23:0] data;   // bytes, first byte in the high bits
    logic [1:0]  count;  // number of bytes, 0..3
    logic        last;   // message ends with this group
  } cmd_t;

  typedef struct packed {
    logic       bad;     // outside the alphabet, '=' included
    logic [5:0] value;
  } lookup_t;

  function automatic lookup_t sextet_of(input logic [7:0] c);
    lookup_t r;
    r.bad   = 1'b0;
    r.value = '0;
    if (c >= 8'h41 && c <= 8'h5a) begin
      r.value = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      r.value = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r.value = 6'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2b) begin
      r.value = 6'd62;
    end else if (c == 8'h2f) begin
      r.value = 6'd63;
    end else begin
      r.bad = 1'b1;
    end
    return r;
  endfunction

endpackage

/* design/b64d_front.sv */
// ----------------------------------------------------------------------------
// b64d_front
// Accepts characters, collects sextets and forms byte groups for the back end.
// ----------------------------------------------------------------------------
`include "base64_stream_decoder_unit_assert.svh"

module b64d_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_char,
  input  logic             end_of_input,
  input  logic             queue_full,
  output logic             push,
  output b64d_pkg::cmd_t   cmd
);

  logic [17:0] sbuf, sbuf_next;
  logic [1:0]  fill, fill_next;
  logic        stopped, stopped_next;
  b64d_pkg::lookup_t lk;
  logic        accept;

  // Partial group of k sextets gives k-1 bytes, left aligned.
  function automatic b64d_pkg::cmd_t flush(input logic [17:0] b, input logic [1:0] k);
    b64d_pkg::cmd_t r;
    r = '0;
    unique case (k)
      2'd2: begin
        r.data  = {b[11:0], 12'b0};
        r.count = 2'd1;
      end
      2'd3: begin
        r.data  = {b, 6'b0};
        r.count = 2'd2;
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;
  assign lk       = b64d_pkg::sextet_of(in_char);

  always_comb begin
    sbuf_next    = sbuf;
    fill_next    = fill;
    stopped_next = stopped;
    cmd          = '0;
    if (!stopped) begin
      if (!lk.bad) begin
        if (fill == b64d_pkg::GROUP_FULL) begin
          cmd.data  = {sbuf, lk.value};
          cmd.count = 2'd3;
          sbuf_next = '0;
          fill_next = '0;
        end else begin
          sbuf_next = {sbuf[11:0], lk.value};
          fill_next = fill + 2'd1;
        end
      end else begin
        stopped_next = 1'b1;
        cmd          = flush(sbuf, fill);
        sbuf_next    = '0;
        fill_next    = '0;
      end
    end
    if (end_of_input) begin
      // at most one group per character: a group emitted above leaves fill at 0
      if (fill_next >= 2'd2) begin
        cmd = flush(sbuf_next, fill_next);
      end
      cmd.last     = 1'b1;
      sbuf_next    = '0;
      fill_next    = '0;
      stopped_next = 1'b0;
    end
  end

  assign push = accept && (cmd.count != 2'd0 || cmd.last);

  always_ff @(posedge clk) begin
    if (rst) begin
      sbuf    <= '0;
      fill    <= '0;
      stopped <= 1'b0;
    end else if (accept) begin
      sbuf    <= sbuf_next;
      fill    <= fill_next;
      stopped <= stopped_next;
    end
  end

  `B64D_ASSERT(a_stop_empty, stopped |-> fill == 2'd0, "front: stopped with pending sextets")

endmodule

/* design/b64d_fifo.sv */
// ----------------------------------------------------------------------------
// b64d_fifo
// Short command queue between front and back end.
// ----------------------------------------------------------------------------
`include "base64_stream_decoder_unit_assert.svh"

module b64d_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  b64d_pkg::cmd_t   push_cmd,
  input  logic             pop,
  output logic             full,
  output logic             not_empty,
  output b64d_pkg::cmd_t   head
);

  localparam int AW = b64d_pkg::QUEUE_AW;

  b64d_pkg::cmd_t entries [b64d_pkg::QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0]   count;
  logic          do_push, do_pop;

  assign full      = count == (AW+1)'(b64d_pkg::QUEUE_DEPTH);
  assign not_empty = count != '0;
  assign head      = entries[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  `B64D_ASSERT(a_no_push_full, push |-> !full, "fifo: push while full")

endmodule

/* design/b64d_back.sv */
// ----------------------------------------------------------------------------
// b64d_back
// Serializes queued groups into bytes, keeps the byte total, marks the end.
// ----------------------------------------------------------------------------
`include "base64_stream_decoder_unit_assert.svh"

module b64d_back #(
  parameter int COUNT_WIDTH = b64d_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  input  b64d_pkg::cmd_t   cmd,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_byte,
  output logic             has_byte,
  output logic             end_of_message,
  output logic [15:0]      byte_count
);

  logic [COUNT_WIDTH-1:0] total, total_inc, total_sel;
  logic [1:0]  idx;
  logic        load, last_byte, bare, eom;
  logic [7:0]  sel_byte;
  logic [15:0] report;

  assign load      = cmd_valid && (!out_valid || out_ready);
  assign bare      = cmd.count == 2'd0;
  assign last_byte = bare || (idx == cmd.count - 2'd1);
  assign eom       = cmd.last && last_byte;
  assign pop       = load && last_byte;
  assign total_inc = (total == '1) ? total : total + 1'b1;
  assign total_sel = bare ? total : total_inc;

  always_comb begin
    unique case (idx)
      2'd0:    sel_byte = cmd.data[23:16];
      2'd1:    sel_byte = cmd.data[15:8];
      2'd2:    sel_byte = cmd.data[7:0];
      default: sel_byte = '0;
    endcase
  end

  // reported total saturates at 16 bits
  always_comb begin
    if (32'(total_sel) > 32'h0000_ffff) begin
      report = 16'hffff;
    end else begin
      report = 16'(total_sel);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
      total     <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= last_byte ? 2'd0 : idx + 2'd1;
        total     <= eom ? '0 : total_sel;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte       <= bare ? 8'd0 : sel_byte;
      has_byte       <= !bare;
      end_of_message <= eom;
      byte_count     <= eom ? report : 16'd0;
    end
  end

  `B64D_ASSERT(a_idx_range, cmd_valid && !bare |-> idx < cmd.count,
               "back: byte index past group")
  `B64D_ASSERT(a_total_clear, load && eom |=> total == '0, "back: total kept after end")

endmodule

/* design/base64_stream_decoder_unit.sv */
// ----------------------------------------------------------------------------
// base64_stream_decoder_unit
// Streaming base64 decoder (standard alphabet) with end marker and byte total.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+----------------------------------------------
//  in      | in_valid / in_ready  | in_char[7:0], end_of_input
//  out     | out_valid / out_ready| out_byte[7:0], has_byte, end_of_message,
//          |                      | byte_count[15:0]
//
//  One character is taken per cycle while the command queue has room; the
//  front decides a character's effect in the cycle it is accepted.
//  The back end sends one output transaction per cycle while out_ready is
//  high and the queue holds a group; four characters give three bytes, one
//  per transaction; each byte passes the queue entry, then the output register.
//  A stalled output fills the four-entry queue, then in_ready drops.
//  Synchronous reset clears sextet state, queue pointers and the byte total.
// ----------------------------------------------------------------------------
`include "base64_stream_decoder_unit_assert.svh"

module base64_stream_decoder_unit #(
  parameter int COUNT_WIDTH = b64d_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char,
  input  logic        end_of_input,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        has_byte,
  output logic        end_of_message,
  output logic [15:0] byte_count
);

  // front -> queue
  logic           push;
  logic           queue_full;
  b64d_pkg::cmd_t push_cmd;

  // queue -> back
  logic           cmd_valid;
  logic           pop;
  b64d_pkg::cmd_t head;

  // Front: alphabet lookup, sextet packing, stop and end handling.
  b64d_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_char      (in_char),
    .end_of_input (end_of_input),
    .queue_full   (queue_full),
    .push         (push),
    .cmd          (push_cmd)
  );

  // Queue: lets the input keep flowing while output transactions stall.
  b64d_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop       (pop),
    .full      (queue_full),
    .not_empty (cmd_valid),
    .head      (head)
  );

  // Back: at most one byte per output transaction, byte total, end marker.
  b64d_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .cmd_valid      (cmd_valid),
    .cmd            (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .has_byte       (has_byte),
    .end_of_message (end_of_message),
    .byte_count     (byte_count)
  );

  // A result without the end mark never carries a count.
  `B64D_ASSERT(a_count_only_at_end, out_valid && !end_of_message |-> byte_count == 16'd0,
               "top: byte count outside end marker")

endmodule
